[src/ccc_pkg.sv]
// Package for the circumcircle block: widths, saturation limits and payload types.
// Used by every other file of the block; depends on nothing.
package ccc_pkg;

	localparam int COORD_BITS = 10;
	localparam int FRAC_BITS  = 4;
	localparam int OUT_BITS   = 24;

	localparam int DIFF_W  = COORD_BITS + 1;
	localparam int SQR_W   = 2 * COORD_BITS;
	localparam int NORM_W  = 2 * COORD_BITS + 1;
	localparam int DPRD_W  = 2 * COORD_BITS + 2;
	localparam int NPRD_W  = NORM_W + 1 + DIFF_W;
	localparam int DET_W   = 2 * COORD_BITS + 3;
	localparam int NUM_W   = 3 * COORD_BITS + 4;
	localparam int DIVN_W  = NUM_W + FRAC_BITS + 1;
	localparam int DIVM_W  = DET_W;
	localparam int BASE_W  = COORD_BITS + FRAC_BITS;
	localparam int UX_W    = DIVN_W + 1;
	localparam int DX_W    = DIVN_W + 2;
	localparam int DIST_BITS = 25;
	localparam int SQ_W    = 2 * DIST_BITS + 1;
	localparam int ROOT_W  = (SQ_W + 1) / 2;
	localparam int RREM_W  = ROOT_W + 3;

	localparam logic signed [OUT_BITS-1:0] OUT_SMAX = {1'b0, {(OUT_BITS - 1){1'b1}}};
	localparam logic signed [OUT_BITS-1:0] OUT_SMIN = {1'b1, {(OUT_BITS - 1){1'b0}}};
	localparam logic [OUT_BITS-1:0] OUT_UMAX = {OUT_BITS{1'b1}};

	typedef logic [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		logic              neg;
		logic              collinear;
		logic [BASE_W-1:0] base;
	} div_tag_t;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] ox;
		logic signed [OUT_BITS-1:0] oy;
		logic                       collinear;
		logic                       ovf;
		logic                       far;
	} res_tag_t;

endpackage

[src/ccc_if.sv]
// Valid/ready channel interfaces for the point triples and the circle results.
// Depends on ccc_pkg for the field types.
interface ccc_points_if;
	logic             valid;
	logic             ready;
	ccc_pkg::coord_t  point_a_x;
	ccc_pkg::coord_t  point_a_y;
	ccc_pkg::coord_t  point_b_x;
	ccc_pkg::coord_t  point_b_y;
	ccc_pkg::coord_t  point_c_x;
	ccc_pkg::coord_t  point_c_y;

	modport source (output valid, point_a_x, point_a_y, point_b_x, point_b_y,
		point_c_x, point_c_y, input ready);
	modport sink (input valid, point_a_x, point_a_y, point_b_x, point_b_y,
		point_c_x, point_c_y, output ready);
endinterface

interface ccc_circle_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [ccc_pkg::OUT_BITS-1:0]  center_x;
	logic signed [ccc_pkg::OUT_BITS-1:0]  center_y;
	logic [ccc_pkg::OUT_BITS-1:0]         radius;
	logic                                 collinear;
	logic                                 overflowed;

	modport source (output valid, center_x, center_y, radius, collinear, overflowed,
		input ready);
	modport sink (input valid, center_x, center_y, radius, collinear, overflowed,
		output ready);
endinterface

[src/ccc_front.sv]
// Front stages: differences and norms, products, sums, then divider operands.
// Depends on ccc_pkg.
module ccc_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_valid,
	input  ccc_pkg::coord_t                ax,
	input  ccc_pkg::coord_t                ay,
	input  ccc_pkg::coord_t                bx,
	input  ccc_pkg::coord_t                by,
	input  ccc_pkg::coord_t                cx,
	input  ccc_pkg::coord_t                cy,
	output logic                           out_valid,
	output logic [ccc_pkg::DIVN_W-1:0]     num_x,
	output logic [ccc_pkg::DIVN_W-1:0]     num_y,
	output logic [ccc_pkg::DIVM_W-1:0]     den,
	output ccc_pkg::div_tag_t              tag_x,
	output ccc_pkg::div_tag_t              tag_y
);
	import ccc_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4;

	coord_t ax_s1, ay_s1, bx_s1, cx_s1;
	logic signed [DIFF_W-1:0] e0_s1, e1_s1, e2_s1, f0_s1, f1_s1, f2_s1;
	logic [NORM_W-1:0] na_s1, nb_s1, nc_s1;

	coord_t ax_s2, ay_s2;
	logic signed [DPRD_W-1:0] pa_s2, pb_s2, pc_s2;
	logic signed [NPRD_W-1:0] qa_s2, qb_s2, qc_s2, ra_s2, rb_s2, rc_s2;

	coord_t ax_s3, ay_s3;
	logic signed [DET_W-1:0] det_s3;
	logic signed [NUM_W-1:0] nx_s3, ny_s3;

	logic [SQR_W-1:0] sqax, sqay, sqbx, sqby, sqcx, sqcy;
	logic signed [DET_W-1:0] det_c;
	logic signed [NUM_W-1:0] nx_c, ny_c;
	logic [NUM_W-1:0] mnx, mny;
	logic [DET_W-1:0] mdet;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_comb begin
		sqax = ax * ax;
		sqay = ay * ay;
		sqbx = bx * bx;
		sqby = by * by;
		sqcx = cx * cx;
		sqcy = cy * cy;
	end

	// Stage 1: coordinate differences and squared norms.
	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1 <= ax;
			ay_s1 <= ay;
			bx_s1 <= bx;
			cx_s1 <= cx;
			e0_s1 <= $signed({1'b0, by}) - $signed({1'b0, cy});
			e1_s1 <= $signed({1'b0, cy}) - $signed({1'b0, ay});
			e2_s1 <= $signed({1'b0, ay}) - $signed({1'b0, by});
			f0_s1 <= $signed({1'b0, cx}) - $signed({1'b0, bx});
			f1_s1 <= $signed({1'b0, ax}) - $signed({1'b0, cx});
			f2_s1 <= $signed({1'b0, bx}) - $signed({1'b0, ax});
			na_s1 <= {1'b0, sqax} + {1'b0, sqay};
			nb_s1 <= {1'b0, sqbx} + {1'b0, sqby};
			nc_s1 <= {1'b0, sqcx} + {1'b0, sqcy};
		end
	end

	// Stage 2: products of coordinates and norms with the differences.
	always_ff @(posedge clk) begin
		if (en) begin
			ax_s2 <= ax_s1;
			ay_s2 <= ay_s1;
			pa_s2 <= $signed({1'b0, ax_s1}) * e0_s1;
			pb_s2 <= $signed({1'b0, bx_s1}) * e1_s1;
			pc_s2 <= $signed({1'b0, cx_s1}) * e2_s1;
			qa_s2 <= $signed({1'b0, na_s1}) * e0_s1;
			qb_s2 <= $signed({1'b0, nb_s1}) * e1_s1;
			qc_s2 <= $signed({1'b0, nc_s1}) * e2_s1;
			ra_s2 <= $signed({1'b0, na_s1}) * f0_s1;
			rb_s2 <= $signed({1'b0, nb_s1}) * f1_s1;
			rc_s2 <= $signed({1'b0, nc_s1}) * f2_s1;
		end
	end

	// Stage 3: determinant and the two numerators. The true values fit, so
	// wrapping in the narrower sums is harmless.
	always_comb begin
		det_c = (DET_W'(pa_s2) + DET_W'(pb_s2) + DET_W'(pc_s2)) <<< 1;
		nx_c  = NUM_W'(qa_s2) + NUM_W'(qb_s2) + NUM_W'(qc_s2);
		ny_c  = NUM_W'(ra_s2) + NUM_W'(rb_s2) + NUM_W'(rc_s2);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s3  <= ax_s2;
			ay_s3  <= ay_s2;
			det_s3 <= det_c;
			nx_s3  <= nx_c;
			ny_s3  <= ny_c;
		end
	end

	// Stage 4: magnitudes and signs; the divider sees (|n| * 2^(FRAC_BITS+1) + |d|) / (2|d|).
	always_comb begin
		mnx  = nx_s3[NUM_W-1] ? NUM_W'(-nx_s3) : NUM_W'(nx_s3);
		mny  = ny_s3[NUM_W-1] ? NUM_W'(-ny_s3) : NUM_W'(ny_s3);
		mdet = det_s3[DET_W-1] ? DET_W'(-det_s3) : DET_W'(det_s3);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_x <= (DIVN_W'(mnx) << (FRAC_BITS + 1)) + DIVN_W'(mdet);
			num_y <= (DIVN_W'(mny) << (FRAC_BITS + 1)) + DIVN_W'(mdet);
			den   <= DIVM_W'(mdet << 1);
			tag_x.neg       <= nx_s3[NUM_W-1] ^ det_s3[DET_W-1];
			tag_x.collinear <= (det_s3 == '0);
			tag_x.base      <= BASE_W'(ax_s3) << FRAC_BITS;
			tag_y.neg       <= ny_s3[NUM_W-1] ^ det_s3[DET_W-1];
			tag_y.collinear <= (det_s3 == '0);
			tag_y.base      <= BASE_W'(ay_s3) << FRAC_BITS;
		end
	end

	assign out_valid = v_s4;

endmodule

[src/ccc_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with a tag alongside.
// Depends on ccc_pkg.
module ccc_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [ccc_pkg::DIVN_W-1:0]  num,
	input  logic [ccc_pkg::DIVM_W-1:0]  den,
	input  ccc_pkg::div_tag_t           tag,
	output logic                        out_valid,
	output logic [ccc_pkg::DIVN_W-1:0]  quo,
	output ccc_pkg::div_tag_t           tag_out
);
	import ccc_pkg::*;

	localparam int NST = DIVN_W;

	logic               vld_s [NST];
	logic [DIVN_W-1:0]  num_s [NST];
	logic [DIVN_W-1:0]  quo_s [NST];
	logic [DIVM_W:0]    rem_s [NST];
	logic [DIVM_W-1:0]  den_s [NST];
	div_tag_t           tag_s [NST];

	logic [DIVN_W-1:0]  num_n [NST];
	logic [DIVN_W-1:0]  quo_n [NST];
	logic [DIVM_W:0]    rem_n [NST];
	logic [DIVM_W-1:0]  den_n [NST];
	div_tag_t           tag_n [NST];

	always_comb begin
		logic [DIVN_W-1:0] pn, pq;
		logic [DIVM_W:0]   pr, trial;
		logic [DIVM_W-1:0] pd;
		for (int k = 0; k < NST; k++) begin
			if (k == 0) begin
				pn = num;
				pq = '0;
				pr = '0;
				pd = den;
				tag_n[k] = tag;
			end else begin
				pn = num_s[k-1];
				pq = quo_s[k-1];
				pr = rem_s[k-1];
				pd = den_s[k-1];
				tag_n[k] = tag_s[k-1];
			end
			trial = {pr[DIVM_W-1:0], pn[DIVN_W-1]};
			if (trial >= {1'b0, pd}) begin
				rem_n[k] = trial - {1'b0, pd};
				quo_n[k] = {pq[DIVN_W-2:0], 1'b1};
			end else begin
				rem_n[k] = trial;
				quo_n[k] = {pq[DIVN_W-2:0], 1'b0};
			end
			num_n[k] = pn << 1;
			den_n[k] = pd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NST; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int k = 1; k < NST; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NST; k++) begin
				num_s[k] <= num_n[k];
				quo_s[k] <= quo_n[k];
				rem_s[k] <= rem_n[k];
				den_s[k] <= den_n[k];
				tag_s[k] <= tag_n[k];
			end
		end
	end

	assign out_valid = vld_s[NST-1];
	assign quo       = quo_s[NST-1];
	assign tag_out   = tag_s[NST-1];

endmodule

[src/ccc_post.sv]
// Middle stages: signed, saturated center, offsets from the first point,
// their squares and the sum that feeds the square root. Depends on ccc_pkg.
module ccc_post (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [ccc_pkg::DIVN_W-1:0]  quo_x,
	input  logic [ccc_pkg::DIVN_W-1:0]  quo_y,
	input  ccc_pkg::div_tag_t           tag_x,
	input  ccc_pkg::div_tag_t           tag_y,
	output logic                        out_valid,
	output logic [ccc_pkg::SQ_W-1:0]    sum_sq,
	output ccc_pkg::res_tag_t           tag_out
);
	import ccc_pkg::*;

	logic v_s5, v_s6, v_s7;
	res_tag_t tag_s5, tag_s6;
	logic [DIST_BITS-1:0] mdx_s5, mdy_s5;
	logic [2*DIST_BITS-1:0] sqx_s6, sqy_s6;

	logic signed [UX_W-1:0] ux, uy;
	logic signed [DX_W-1:0] dx, dy;
	logic [DX_W-1:0] mdx, mdy;
	logic ovx, ovy;
	logic signed [OUT_BITS-1:0] ox, oy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s5 <= in_valid;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_comb begin
		ux = tag_x.neg ? -$signed({1'b0, quo_x}) : $signed({1'b0, quo_x});
		uy = tag_y.neg ? -$signed({1'b0, quo_y}) : $signed({1'b0, quo_y});
		ovx = 1'b0;
		ovy = 1'b0;
		if (ux > UX_W'(OUT_SMAX)) begin
			ox = OUT_SMAX;
			ovx = 1'b1;
		end else if (ux < UX_W'(OUT_SMIN)) begin
			ox = OUT_SMIN;
			ovx = 1'b1;
		end else begin
			ox = OUT_BITS'(ux);
		end
		if (uy > UX_W'(OUT_SMAX)) begin
			oy = OUT_SMAX;
			ovy = 1'b1;
		end else if (uy < UX_W'(OUT_SMIN)) begin
			oy = OUT_SMIN;
			ovy = 1'b1;
		end else begin
			oy = OUT_BITS'(uy);
		end
		dx  = DX_W'($signed({1'b0, tag_x.base})) - DX_W'(ux);
		dy  = DX_W'($signed({1'b0, tag_y.base})) - DX_W'(uy);
		mdx = dx[DX_W-1] ? DX_W'(-dx) : DX_W'(dx);
		mdy = dy[DX_W-1] ? DX_W'(-dy) : DX_W'(dy);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s5.ox        <= ox;
			tag_s5.oy        <= oy;
			tag_s5.collinear <= tag_x.collinear;
			tag_s5.ovf       <= ovx | ovy;
			tag_s5.far       <= (mdx[DX_W-1:DIST_BITS] != '0) ||
				(mdy[DX_W-1:DIST_BITS] != '0);
			mdx_s5 <= mdx[DIST_BITS-1:0];
			mdy_s5 <= mdy[DIST_BITS-1:0];

			tag_s6 <= tag_s5;
			sqx_s6 <= mdx_s5 * mdx_s5;
			sqy_s6 <= mdy_s5 * mdy_s5;

			tag_out <= tag_s6;
			sum_sq  <= {1'b0, sqx_s6} + {1'b0, sqy_s6};
		end
	end

	assign out_valid = v_s7;

endmodule

[src/ccc_sqrt.sv]
// Pipelined digit-by-digit integer square root, one root bit per stage,
// giving the floor root and its remainder. Depends on ccc_pkg.
module ccc_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [ccc_pkg::SQ_W-1:0]    rad,
	input  ccc_pkg::res_tag_t           tag,
	output logic                        out_valid,
	output logic [ccc_pkg::ROOT_W-1:0]  root,
	output logic [ccc_pkg::RREM_W-1:0]  rem,
	output ccc_pkg::res_tag_t           tag_out
);
	import ccc_pkg::*;

	localparam int NST = ROOT_W;
	localparam int RAD_W = 2 * ROOT_W;

	logic               vld_s  [NST];
	logic [RAD_W-1:0]   rad_s  [NST];
	logic [ROOT_W-1:0]  root_s [NST];
	logic [RREM_W-1:0]  rem_s  [NST];
	res_tag_t           tag_s  [NST];

	logic [RAD_W-1:0]   rad_n  [NST];
	logic [ROOT_W-1:0]  root_n [NST];
	logic [RREM_W-1:0]  rem_n  [NST];
	res_tag_t           tag_n  [NST];

	always_comb begin
		logic [RAD_W-1:0]  pa;
		logic [ROOT_W-1:0] pr;
		logic [RREM_W-1:0] pm, cur, trial;
		for (int k = 0; k < NST; k++) begin
			if (k == 0) begin
				pa = RAD_W'(rad);
				pr = '0;
				pm = '0;
				tag_n[k] = tag;
			end else begin
				pa = rad_s[k-1];
				pr = root_s[k-1];
				pm = rem_s[k-1];
				tag_n[k] = tag_s[k-1];
			end
			cur   = {pm[RREM_W-3:0], pa[RAD_W-1 -: 2]};
			trial = RREM_W'({pr, 2'b01});
			if (cur >= trial) begin
				rem_n[k]  = cur - trial;
				root_n[k] = {pr[ROOT_W-2:0], 1'b1};
			end else begin
				rem_n[k]  = cur;
				root_n[k] = {pr[ROOT_W-2:0], 1'b0};
			end
			rad_n[k] = pa << 2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NST; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int k = 1; k < NST; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NST; k++) begin
				rad_s[k]  <= rad_n[k];
				root_s[k] <= root_n[k];
				rem_s[k]  <= rem_n[k];
				tag_s[k]  <= tag_n[k];
			end
		end
	end

	assign out_valid = vld_s[NST-1];
	assign root      = root_s[NST-1];
	assign rem       = rem_s[NST-1];
	assign tag_out   = tag_s[NST-1];

endmodule

[src/circumcircle_of_three_points_top.sv]
// Top level of the circumcircle block: front arithmetic, two dividers,
// offset stages, square root and the output register. Depends on ccc_pkg and ccc_if.
//
// Each transaction on the points channel carries three pixel points; exactly one
// transaction follows on the circle channel, in order, with the center in signed
// fixed point and the radius in unsigned fixed point (FRAC_BITS fraction bits,
// rounded to nearest, saturated with the overflowed flag), or zeros with the
// collinear flag when the three points lie on one line. The block accepts one
// transaction every cycle while the circle channel is not stalled, and keeps every
// stage busy. At the default widths the pipeline is: four front stages for
// differences, products, sums and divider operands, one stage per quotient bit
// in the restoring dividers (DIVN_W = 39), three stages for the center and the
// squared distance, one stage per root bit in the square root (ROOT_W = 26), and
// the output register. The whole pipeline advances as one: when a result sits in
// the output register and the sink holds ready low, every stage holds, and ready
// on the points channel falls in the same cycle, so nothing is lost or taken twice.
module circumcircle_of_three_points_top (
	input  logic           clk,
	input  logic           arst_n,
	ccc_points_if.sink     points,
	ccc_circle_if.source   circle
);
	import ccc_pkg::*;

	logic en;
	logic out_vld_q;

	logic front_valid;
	logic [DIVN_W-1:0] num_x, num_y;
	logic [DIVM_W-1:0] den;
	div_tag_t tag_x, tag_y, dtag_x, dtag_y;
	logic divx_valid, divy_valid;
	logic [DIVN_W-1:0] quo_x, quo_y;
	logic post_valid;
	logic [SQ_W-1:0] sum_sq;
	res_tag_t post_tag, sq_tag;
	logic sq_valid;
	logic [ROOT_W-1:0] root;
	logic [RREM_W-1:0] rem;

	logic [ROOT_W:0] root_rnd;
	logic signed [OUT_BITS-1:0] cx_n, cy_n;
	logic [OUT_BITS-1:0] rad_n;
	logic col_n, ovf_n;

	// Global advance: the pipeline moves whenever the output register is free
	// or being emptied in this cycle.
	assign en = !out_vld_q || circle.ready;
	assign points.ready = en;

	ccc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (points.valid),
		.ax        (points.point_a_x),
		.ay        (points.point_a_y),
		.bx        (points.point_b_x),
		.by        (points.point_b_y),
		.cx        (points.point_c_x),
		.cy        (points.point_c_y),
		.out_valid (front_valid),
		.num_x     (num_x),
		.num_y     (num_y),
		.den       (den),
		.tag_x     (tag_x),
		.tag_y     (tag_y)
	);

	ccc_div u_div_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (front_valid),
		.num       (num_x),
		.den       (den),
		.tag       (tag_x),
		.out_valid (divx_valid),
		.quo       (quo_x),
		.tag_out   (dtag_x)
	);

	ccc_div u_div_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (front_valid),
		.num       (num_y),
		.den       (den),
		.tag       (tag_y),
		.out_valid (divy_valid),
		.quo       (quo_y),
		.tag_out   (dtag_y)
	);

	// Both dividers move in lockstep, so their valid bits always agree.
	ccc_post u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (divx_valid & divy_valid),
		.quo_x     (quo_x),
		.quo_y     (quo_y),
		.tag_x     (dtag_x),
		.tag_y     (dtag_y),
		.out_valid (post_valid),
		.sum_sq    (sum_sq),
		.tag_out   (post_tag)
	);

	ccc_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (post_valid),
		.rad       (sum_sq),
		.tag       (post_tag),
		.out_valid (sq_valid),
		.root      (root),
		.rem       (rem),
		.tag_out   (sq_tag)
	);

	// Final rounding of the radius: the floor root goes up by one when the
	// remainder exceeds the root, which is rounding to nearest with ties up.
	always_comb begin
		root_rnd = {1'b0, root} + ((rem > RREM_W'(root)) ? (ROOT_W + 1)'(1) : '0);
		cx_n  = sq_tag.ox;
		cy_n  = sq_tag.oy;
		col_n = 1'b0;
		ovf_n = sq_tag.ovf;
		if (sq_tag.far) begin
			rad_n = OUT_UMAX;
			ovf_n = 1'b1;
		end else if (root_rnd > (ROOT_W + 1)'(OUT_UMAX)) begin
			rad_n = OUT_UMAX;
			ovf_n = 1'b1;
		end else begin
			rad_n = OUT_BITS'(root_rnd);
		end
		if (sq_tag.collinear) begin
			cx_n  = '0;
			cy_n  = '0;
			rad_n = '0;
			col_n = 1'b1;
			ovf_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= sq_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			circle.center_x   <= cx_n;
			circle.center_y   <= cy_n;
			circle.radius     <= rad_n;
			circle.collinear  <= col_n;
			circle.overflowed <= ovf_n;
		end
	end

	assign circle.valid = out_vld_q;

endmodule
